### rtl/core/adp_rc4_pkg.sv
// ----------------------------------------------------------------------------
// adp_rc4_pkg
// shared types, constants and command codes of the rc4 voice decrypt unit
// ----------------------------------------------------------------------------
package adp_rc4_pkg;

   // keystream store depth (469 .. 512)
   localparam int STREAM_LEN = 469;
   localparam int STREAM_AW  = $clog2(STREAM_LEN);

   localparam int KEY_BYTES        = 13;
   localparam int CW_BYTES         = 11;
   localparam int FRAMES           = 9;
   localparam int BASE_OFFSET      = 267;
   localparam int LDU2_OFFSET      = 101;
   localparam int LAST_FRAME_EXTRA = 2;
   localparam int PERM_DEPTH       = 256;

   // offsets stay below 512 for every frame position
   localparam int OFF_W = 10;

   localparam logic MODE_PREPARE  = 1'b0;
   localparam logic MODE_CODEWORD = 1'b1;
   localparam logic KIND_BYTE     = 1'b0;
   localparam logic KIND_PREPARE  = 1'b1;

   localparam logic [3:0] CSR_ADDR_KEY = 4'h0;

   typedef struct packed {
      logic        mode;
      logic [63:0] message_indicator;
      logic        second_frame_kind;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] plain_byte;
      logic       codeword_end;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CW_READ,
      OP_CW_EMIT,
      OP_PREP_EMIT,
      OP_INIT_WR,
      OP_K_RD_I,
      OP_K_RD_J,
      OP_K_WR_I,
      OP_K_WR_J,
      OP_P_RD_I,
      OP_P_RD_J,
      OP_P_WR_I,
      OP_P_WR_J,
      OP_P_RD_K,
      OP_P_WR_S
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_req;  // latch request payload
      logic      clr;       // restart walk counters
   } cmd_type;

   typedef struct packed {
      logic idx_last_perm;
      logic idx_last_stream;
      logic out_free;
   } status_type;

   // keystream offset of the first byte of a codeword at a frame position
   function automatic logic [OFF_W-1:0] frame_base(input logic [3:0] pos);
      logic [OFF_W-1:0] base;
      base = OFF_W'(BASE_OFFSET) + OFF_W'(CW_BYTES) * OFF_W'(pos);
      if (pos == 4'(FRAMES - 1)) begin
         base = base + OFF_W'(LAST_FRAME_EXTRA);
      end
      return base;
   endfunction

endpackage

### rtl/core/adp_rc4_ctrl.sv
// ----------------------------------------------------------------------------
// adp_rc4_ctrl
// sequencer for request handling, key schedule and keystream generation
// ----------------------------------------------------------------------------
module adp_rc4_ctrl
   import adp_rc4_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_mode,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CW_OUT,
      ST_INIT,
      ST_K_RD_I,
      ST_K_RD_J,
      ST_K_WR_I,
      ST_K_WR_J,
      ST_P_RD_I,
      ST_P_RD_J,
      ST_P_WR_I,
      ST_P_WR_J,
      ST_P_RD_K,
      ST_P_WR_S,
      ST_PREP_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.load_req = 1'b0;
      cmd.clr      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_mode == MODE_CODEWORD) begin
                  cmd.op   = OP_CW_READ;
                  state_in = ST_CW_OUT;
               end else begin
                  cmd.clr  = 1'b1;
                  state_in = ST_INIT;
               end
            end
         end
         ST_CW_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_CW_EMIT;
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            cmd.op = OP_INIT_WR;
            if (status.idx_last_perm) begin
               cmd.clr  = 1'b1;
               state_in = ST_K_RD_I;
            end
         end
         ST_K_RD_I: begin
            cmd.op   = OP_K_RD_I;
            state_in = ST_K_RD_J;
         end
         ST_K_RD_J: begin
            cmd.op   = OP_K_RD_J;
            state_in = ST_K_WR_I;
         end
         ST_K_WR_I: begin
            cmd.op   = OP_K_WR_I;
            state_in = ST_K_WR_J;
         end
         ST_K_WR_J: begin
            cmd.op = OP_K_WR_J;
            if (status.idx_last_perm) begin
               cmd.clr  = 1'b1;
               state_in = ST_P_RD_I;
            end else begin
               state_in = ST_K_RD_I;
            end
         end
         ST_P_RD_I: begin
            cmd.op   = OP_P_RD_I;
            state_in = ST_P_RD_J;
         end
         ST_P_RD_J: begin
            cmd.op   = OP_P_RD_J;
            state_in = ST_P_WR_I;
         end
         ST_P_WR_I: begin
            cmd.op   = OP_P_WR_I;
            state_in = ST_P_WR_J;
         end
         ST_P_WR_J: begin
            cmd.op   = OP_P_WR_J;
            state_in = ST_P_RD_K;
         end
         ST_P_RD_K: begin
            cmd.op   = OP_P_RD_K;
            state_in = ST_P_WR_S;
         end
         ST_P_WR_S: begin
            cmd.op   = OP_P_WR_S;
            state_in = status.idx_last_stream ? ST_PREP_OUT : ST_P_RD_I;
         end
         ST_PREP_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_PREP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/adp_rc4_dp.sv
// ----------------------------------------------------------------------------
// adp_rc4_dp
// permutation and keystream memories, walk registers, frame counters, output
// ----------------------------------------------------------------------------
module adp_rc4_dp
   import adp_rc4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  req_type     req_payload,
   input  logic [39:0] cipher_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload
);

   // memories
   logic [7:0] perm_ff   [PERM_DEPTH];
   logic [7:0] stream_ff [STREAM_LEN];
   logic [7:0] perm_rdata_ff;
   logic [7:0] stream_rdata_ff;

   // walk registers
   logic [STREAM_AW-1:0] idx_ff;
   logic [STREAM_AW-1:0] idx_in;
   logic [7:0]           i_ff, i_in;
   logic [7:0]           j_ff, j_in;
   logic [7:0]           si_ff, si_in;
   logic [7:0]           sj_ff, sj_in;
   logic [3:0]           key_idx_ff, key_idx_in;

   // latched request
   req_type req_ff;
   logic    in_range_ff, in_range_in;

   // frame state
   logic [3:0] frame_pos_ff, frame_pos_in;
   logic [3:0] byte_cw_ff, byte_cw_in;
   logic       ready_ff, ready_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   // memory port controls
   logic       perm_we, perm_re;
   logic [7:0] perm_waddr, perm_raddr, perm_wdata;
   logic       stream_we, stream_re;

   logic [103:0]     key_vec;
   logic [7:0]       key_byte;
   logic [OFF_W-1:0] off_sum;
   logic             off_ok;
   logic             cw_end;

   assign key_vec  = {cipher_key, req_ff.message_indicator};
   assign key_byte = key_vec[8 * (KEY_BYTES - 1 - int'(key_idx_ff)) +: 8];

   assign off_sum = frame_base(frame_pos_ff)
                  + (req_payload.second_frame_kind ? OFF_W'(LDU2_OFFSET) : '0)
                  + OFF_W'(byte_cw_ff);
   assign off_ok  = (off_sum < OFF_W'(STREAM_LEN));
   assign cw_end  = (byte_cw_ff == 4'(CW_BYTES - 1));

   always_comb begin
      idx_in       = idx_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      key_idx_in   = key_idx_ff;
      in_range_in  = in_range_ff;
      frame_pos_in = frame_pos_ff;
      byte_cw_in   = byte_cw_ff;
      ready_in     = ready_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      perm_we      = 1'b0;
      perm_re      = 1'b0;
      perm_waddr   = idx_ff[7:0];
      perm_raddr   = idx_ff[7:0];
      perm_wdata   = perm_rdata_ff;
      stream_we    = 1'b0;
      stream_re    = 1'b0;
      case (cmd.op)
         OP_CW_READ: begin
            in_range_in = off_ok;
            stream_re   = off_ok;
         end
         OP_CW_EMIT: begin
            rsp_in.result_kind  = KIND_BYTE;
            rsp_in.codeword_end = cw_end;
            rsp_in.plain_byte   = (ready_ff && in_range_ff)
                                ? (req_ff.data_byte ^ stream_rdata_ff)
                                : req_ff.data_byte;
            rsp_valid_in = 1'b1;
            if (cw_end) begin
               byte_cw_in   = '0;
               frame_pos_in = (frame_pos_ff == 4'(FRAMES - 1)) ? '0 : frame_pos_ff + 4'd1;
            end else begin
               byte_cw_in = byte_cw_ff + 4'd1;
            end
         end
         OP_PREP_EMIT: begin
            rsp_in.result_kind  = KIND_PREPARE;
            rsp_in.plain_byte   = '0;
            rsp_in.codeword_end = 1'b0;
            rsp_valid_in = 1'b1;
            ready_in     = 1'b1;
            frame_pos_in = '0;
            byte_cw_in   = '0;
         end
         OP_INIT_WR: begin
            perm_we    = 1'b1;
            perm_wdata = idx_ff[7:0];
            idx_in     = idx_ff + 1'b1;
         end
         OP_K_RD_I: begin
            perm_re = 1'b1;
         end
         OP_K_RD_J: begin
            si_in      = perm_rdata_ff;
            j_in       = j_ff + perm_rdata_ff + key_byte;
            perm_re    = 1'b1;
            perm_raddr = j_in;
         end
         OP_K_WR_I: begin
            perm_we = 1'b1;
         end
         OP_K_WR_J: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            idx_in     = idx_ff + 1'b1;
            key_idx_in = (key_idx_ff == 4'(KEY_BYTES - 1)) ? '0 : key_idx_ff + 4'd1;
         end
         OP_P_RD_I: begin
            i_in       = i_ff + 8'd1;
            perm_re    = 1'b1;
            perm_raddr = i_in;
         end
         OP_P_RD_J: begin
            si_in      = perm_rdata_ff;
            j_in       = j_ff + perm_rdata_ff;
            perm_re    = 1'b1;
            perm_raddr = j_in;
         end
         OP_P_WR_I: begin
            sj_in      = perm_rdata_ff;
            perm_we    = 1'b1;
            perm_waddr = i_ff;
         end
         OP_P_WR_J: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
         end
         OP_P_RD_K: begin
            perm_re    = 1'b1;
            perm_raddr = si_ff + sj_ff;
         end
         OP_P_WR_S: begin
            stream_we = 1'b1;
            idx_in    = idx_ff + 1'b1;
         end
         default: begin
         end
      endcase
      if (cmd.clr) begin
         idx_in     = '0;
         i_in       = '0;
         j_in       = '0;
         key_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_ff[perm_waddr] <= perm_wdata;
      end
      if (perm_re) begin
         perm_rdata_ff <= perm_ff[perm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stream_we) begin
         stream_ff[idx_ff] <= perm_rdata_ff;
      end
      if (stream_re) begin
         stream_rdata_ff <= stream_ff[off_sum[STREAM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      key_idx_ff  <= key_idx_in;
      in_range_ff <= in_range_in;
      rsp_ff      <= rsp_in;
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff <= '0;
         byte_cw_ff   <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_pos_ff <= frame_pos_in;
         byte_cw_ff   <= byte_cw_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.idx_last_perm   = (idx_ff == STREAM_AW'(PERM_DEPTH - 1));
   assign status.idx_last_stream = (idx_ff == STREAM_AW'(STREAM_LEN - 1));
   assign status.out_free        = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/core/adp_rc4_voice_decrypt_unit.sv
// ----------------------------------------------------------------------------
// adp_rc4_voice_decrypt_unit
// rc4 voice decryptor: prepare requests build the keystream from the cipher
// key and message indicator, codeword requests xor one byte each
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------
//  req_     | in        | req_valid / req_ready  | req_type (mode, mi, ...)
//  rsp_     | out       | rsp_valid / rsp_ready  | rsp_type (kind, byte, end)
//  csr_     | in        | apb write, pready = 1  | cipher_key at address 0
//
//  a codeword request is accepted and reads the keystream store; once the
//  output register is free, the xor result loads it
//  a prepare request fills the permutation memory (256 entries), runs the
//  key schedule (256 steps) and writes the keystream (469 bytes), each step
//  sequenced around the single write port of the permutation memory
//  one request is in work at a time; req_ready is high only while idle
//  a held result in the output register stalls the sequencer at its last step
//  synchronous active-high reset clears frame counters, flags, key and sequencer;
//  memories have no reset and keystream bytes are used only after a prepare fills them
//
module adp_rc4_voice_decrypt_unit
   import adp_rc4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [39:0] key_ff;
   logic        csr_write;
   cmd_type     cmd;
   status_type  status;

   // register write in the access phase
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write && (csr_paddr == CSR_ADDR_KEY)) begin
         key_ff <= csr_pwdata[39:0];
      end
   end

   // read back, unmapped addresses read zero
   assign csr_prdata = (csr_paddr == CSR_ADDR_KEY) ? {24'd0, key_ff} : '0;

   // sequencer
   adp_rc4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_payload.mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, walk registers and output register
   adp_rc4_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .cipher_key  (key_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
